@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the length-field deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside of reset.
`define LFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside of reset.
`define LFD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define LFD_ASSERT(lbl, prop, msg)
`define LFD_NEVER(lbl, expr, msg)

`endif

`endif

@@ design/lfd_pkg.sv @@
// Types and constants shared by the length-field deframer modules.
`default_nettype none

package lfd_pkg;

	// Register indexes on the configuration port (byte address = 4 * index)
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned ADDR_W    = 5;

	localparam logic [REG_IDX_W-1:0] REG_PREFIX_BYTES = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH_BYTES = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SUFFIX_BYTES = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COVERS_ALL   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TICK_LIMIT   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RUN_LIMIT    = 3'd5;

	// Register reset values
	localparam logic [3:0]  RST_PREFIX_BYTES = 4'd0;
	localparam logic [2:0]  RST_LENGTH_BYTES = 3'd1;
	localparam logic [3:0]  RST_SUFFIX_BYTES = 4'd0;
	localparam logic        RST_COVERS_ALL   = 1'b0;
	localparam logic [15:0] RST_TICK_LIMIT   = 16'd1000;
	localparam logic [7:0]  RST_RUN_LIMIT    = 8'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT    = 2'd1;
	localparam logic [1:0] STATUS_DISCONNECT = 2'd2;

	// Input word kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam int unsigned COUNT_W = 33;

	typedef struct packed {
		logic [3:0]  prefix_bytes;
		logic [2:0]  length_bytes;
		logic [3:0]  suffix_bytes;
		logic        length_covers_all;
		logic [15:0] silence_tick_limit;
		logic [7:0]  timeout_run_limit;
	} cfg_t;

	typedef struct packed {
		logic               has_byte;
		logic [7:0]         out_byte;
		logic [COUNT_W-1:0] byte_count;
		logic               frame_last;
		logic [1:0]         status;
	} res_t;

endpackage

`default_nettype wire

@@ design/lfd_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module lfd_regs
	import lfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prefix_bytes       <= RST_PREFIX_BYTES;
			cfg_q.length_bytes       <= RST_LENGTH_BYTES;
			cfg_q.suffix_bytes       <= RST_SUFFIX_BYTES;
			cfg_q.length_covers_all  <= RST_COVERS_ALL;
			cfg_q.silence_tick_limit <= RST_TICK_LIMIT;
			cfg_q.timeout_run_limit  <= RST_RUN_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_PREFIX_BYTES: cfg_q.prefix_bytes       <= pwdata[3:0];
				REG_LENGTH_BYTES: cfg_q.length_bytes       <= pwdata[2:0];
				REG_SUFFIX_BYTES: cfg_q.suffix_bytes       <= pwdata[3:0];
				REG_COVERS_ALL:   cfg_q.length_covers_all  <= pwdata[0];
				REG_TICK_LIMIT:   cfg_q.silence_tick_limit <= pwdata[15:0];
				REG_RUN_LIMIT:    cfg_q.timeout_run_limit  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero above its width
	always_comb begin
		unique case (idx)
			REG_PREFIX_BYTES: prdata = {28'd0, cfg_q.prefix_bytes};
			REG_LENGTH_BYTES: prdata = {29'd0, cfg_q.length_bytes};
			REG_SUFFIX_BYTES: prdata = {28'd0, cfg_q.suffix_bytes};
			REG_COVERS_ALL:   prdata = {31'd0, cfg_q.length_covers_all};
			REG_TICK_LIMIT:   prdata = {16'd0, cfg_q.silence_tick_limit};
			REG_RUN_LIMIT:    prdata = {24'd0, cfg_q.timeout_run_limit};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ design/lfd_core.sv @@
// Frame and silence state with the per-word result logic.
`default_nettype none

module lfd_core
	import lfd_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output res_t       res
);

	localparam int unsigned LW = 8 * MAX_LENGTH_BYTES;

	logic [COUNT_W-1:0] pos_q;
	logic [LW-1:0]      len_q;
	logic [COUNT_W-1:0] total_q;
	logic [15:0]        silence_q;
	logic [7:0]         runs_q;

	logic [2:0]         eff_len;
	logic [4:0]         field_end;
	logic [5:0]         fixed_sum;
	logic [COUNT_W-1:0] pos_inc;
	logic               in_field;
	logic               at_end;
	logic [LW-1:0]      len_next;
	logic [COUNT_W-1:0] total_base;
	logic [COUNT_W-1:0] total_next;
	logic               last;
	logic [15:0]        sil_inc;
	logic               disc;
	logic               tmo;

	// Fixed frame sizes from the current registers
	assign eff_len   = (cfg.length_bytes > 3'(MAX_LENGTH_BYTES)) ?
		3'(MAX_LENGTH_BYTES) : cfg.length_bytes;
	assign field_end = {1'b0, cfg.prefix_bytes} + {2'b0, eff_len};
	assign fixed_sum = {1'b0, field_end} + {2'b0, cfg.suffix_bytes};

	// Byte path: advance the count, gather the length, find the frame end
	assign pos_inc    = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign in_field   = (pos_inc > COUNT_W'(cfg.prefix_bytes)) &&
		(pos_inc <= COUNT_W'(field_end));
	assign at_end     = (pos_inc == COUNT_W'(field_end));
	assign len_next   = in_field ? LW'({len_q, rx_byte}) : len_q;
	assign total_base = (pos_q == '0) ? COUNT_W'(fixed_sum) : total_q;
	always_comb begin
		if (!at_end) begin
			total_next = total_base;
		end else if (cfg.length_covers_all) begin
			total_next = COUNT_W'(len_next);
		end else begin
			total_next = COUNT_W'(fixed_sum) + COUNT_W'(len_next);
		end
	end
	assign last = (pos_inc >= total_next);

	// Tick path: count silence, then disconnection before timeout
	assign sil_inc = (&silence_q) ? silence_q : silence_q + 1'b1;
	assign disc    = (runs_q >= cfg.timeout_run_limit);
	assign tmo     = !disc && (sil_inc >= cfg.silence_tick_limit);

	// Build the result for the word in flight
	always_comb begin
		res_valid      = 1'b1;
		res.has_byte   = 1'b1;
		res.out_byte   = rx_byte;
		res.byte_count = pos_inc;
		res.frame_last = last;
		res.status     = STATUS_OK;
		if (mode == MODE_TICK) begin
			res_valid      = disc || tmo;
			res.has_byte   = 1'b0;
			res.out_byte   = 8'd0;
			res.byte_count = pos_q;
			res.frame_last = 1'b0;
			res.status     = disc ? STATUS_DISCONNECT : STATUS_TIMEOUT;
		end
	end

	// Update the state once per word taken from the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			total_q   <= '0;
			silence_q <= '0;
			runs_q    <= '0;
		end else if (step) begin
			if (mode == MODE_BYTE) begin
				silence_q <= '0;
				runs_q    <= '0;
				total_q   <= total_next;
				if (last) begin
					pos_q <= '0;
					len_q <= '0;
				end else begin
					pos_q <= pos_inc;
					len_q <= len_next;
				end
			end else if (disc) begin
				silence_q <= sil_inc;
				runs_q    <= '0;
				pos_q     <= '0;
				len_q     <= '0;
			end else if (tmo) begin
				silence_q <= '0;
				runs_q    <= runs_q + 1'b1;
				pos_q     <= '0;
				len_q     <= '0;
			end else begin
				silence_q <= sil_inc;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/length_field_deframer_with_timeout.sv @@
// Top level of the length-field deframer with silence timeout.
//
//  port group   dir  fields (low bit first)
//  s_*          in   tdata: rx_byte[7:0]; tuser: mode
//  m_*          out  tdata: out_byte[7:0], byte_count[40:8], zero[47:41];
//                    tuser: has_byte, status[2:1]; tlast: frame_last
//  p*           cfg  APB-style registers at byte address 4 * index
//
// One word per cycle is sustained while m_tready is high; a word accepted on s_*
// passes the input register, then the result register, before it shows on m_*.
// Frame state updates as a word moves from the input register to the result
// register; an idle tick that gives no result leaves nothing on m_*.
// A stall on m_tready holds the result register and the input register; the
// input side keeps taking words while the input register can move on.
// Reset clears all control and frame state and loads the register defaults.
`default_nettype none

module length_field_deframer_with_timeout
	import lfd_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_BYTES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// stream in
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // rx_byte[7:0]
	input  logic              s_tuser,   // mode
	// stream out
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,   // out_byte[7:0], byte_count[40:8], zero[47:41]
	output logic [2:0]        m_tuser,   // has_byte[0], status[2:1]
	output logic              m_tlast,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	`include "assert_macros.svh"

	cfg_t       cfg;
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       res_valid;
	res_t       res;
	logic       load_out;
	logic       out_valid_q;
	res_t       out_q;

	lfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Move the input word on when the result register can take its result
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign load_out = adv && res_valid;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	lfd_core #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (adv),
		.mode      (mode_s1),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.byte_count, out_q.out_byte};
	assign m_tuser  = {out_q.status, out_q.has_byte};
	assign m_tlast  = out_q.frame_last;

	// Checks
	`LFD_ASSERT(a_ready_when_empty, !valid_s1 |-> s_tready, "input register empty but not ready")
	`LFD_NEVER(a_no_overwrite, load_out && out_valid_q && !m_tready, "result overwritten")
	`LFD_NEVER(a_last_needs_byte, m_tvalid && m_tlast && !m_tuser[0], "frame end without byte")
	`LFD_NEVER(a_byte_status_ok, m_tvalid && m_tuser[0] && (m_tuser[2:1] != STATUS_OK),
		"byte result with error status")

endmodule

`default_nettype wire
